// File: rtl/hs_pkg.sv
`default_nettype none

package hs_pkg;

  localparam int unsigned MAX_ITEMS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
  // holds a count from 0 up to MAX_ITEMS
  localparam int unsigned CNT_W     = ADDR_W + 1;
  // holds a child index 2*node+2 for any node below MAX_ITEMS
  localparam int unsigned CHILD_W   = ADDR_W + 2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BUILD_INIT,
    ST_SIFT_START,
    ST_SIFT_LOAD,
    ST_SIFT_READ,
    ST_SIFT_CMP,
    ST_EXT_READ,
    ST_EXT_CAP
  } hs_state_t;

  typedef enum logic [1:0] {
    RD_BIDX,
    RD_CHILDREN,
    RD_EXTRACT
  } hs_rd_sel_t;

  typedef struct packed {
    logic       load_en;
    logic       build_init;
    logic       node_from_bidx;
    logic       bidx_dec;
    logic       cur_from_a;
    logic       sift_cmp;
    logic       ext_cap;
    logic       batch_clear;
    hs_rd_sel_t rd_sel;
  } hs_cmd_t;

  typedef struct packed {
    logic last_accepted;
    logic n_small;
    logic bidx_zero;
    logic sift_done;
    logic out_free;
    logic live_one;
  } hs_status_t;

endpackage

`default_nettype wire

// File: rtl/hs_in_if.sv
`default_nettype none

interface hs_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [hs_pkg::DATA_W-1:0] value;
  logic                             last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

`default_nettype wire

// File: rtl/hs_out_if.sv
`default_nettype none

interface hs_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [hs_pkg::DATA_W-1:0] sorted_value;
  logic                             last_result;
  logic                             overflowed;

  modport source (output valid, output sorted_value, output last_result,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input last_result,
                  input overflowed, output ready);
endinterface

`default_nettype wire

// File: rtl/hs_ram.sv
`default_nettype none

module hs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// File: rtl/hs_ctrl.sv
`default_nettype none

module hs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  hs_pkg::hs_status_t status,
  output hs_pkg::hs_cmd_t    cmd
);

  hs_pkg::hs_state_t state;
  hs_pkg::hs_state_t state_next;
  logic              building;
  logic              building_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hs_pkg::ST_LOAD;
      building <= 1'b0;
    end else begin
      state    <= state_next;
      building <= building_next;
    end
  end

  always_comb begin
    state_next    = state;
    building_next = building;
    cmd           = '0;
    cmd.rd_sel    = hs_pkg::RD_CHILDREN;
    case (state)
      hs_pkg::ST_LOAD: begin
        cmd.load_en = 1'b1;
        if (status.last_accepted) begin
          state_next = hs_pkg::ST_BUILD_INIT;
        end
      end
      hs_pkg::ST_BUILD_INIT: begin
        cmd.build_init = 1'b1;
        if (status.n_small) begin
          state_next = hs_pkg::ST_EXT_READ;
        end else begin
          building_next = 1'b1;
          state_next    = hs_pkg::ST_SIFT_START;
        end
      end
      hs_pkg::ST_SIFT_START: begin
        cmd.rd_sel         = hs_pkg::RD_BIDX;
        cmd.node_from_bidx = 1'b1;
        state_next         = hs_pkg::ST_SIFT_LOAD;
      end
      hs_pkg::ST_SIFT_LOAD: begin
        cmd.cur_from_a = 1'b1;
        state_next     = hs_pkg::ST_SIFT_CMP;
      end
      hs_pkg::ST_SIFT_READ: begin
        state_next = hs_pkg::ST_SIFT_CMP;
      end
      hs_pkg::ST_SIFT_CMP: begin
        cmd.sift_cmp = 1'b1;
        if (!status.sift_done) begin
          state_next = hs_pkg::ST_SIFT_READ;
        end else if (building && !status.bidx_zero) begin
          cmd.bidx_dec = 1'b1;
          state_next   = hs_pkg::ST_SIFT_START;
        end else begin
          building_next = 1'b0;
          state_next    = hs_pkg::ST_EXT_READ;
        end
      end
      hs_pkg::ST_EXT_READ: begin
        cmd.rd_sel = hs_pkg::RD_EXTRACT;
        if (status.out_free) begin
          state_next = hs_pkg::ST_EXT_CAP;
        end
      end
      hs_pkg::ST_EXT_CAP: begin
        cmd.ext_cap = 1'b1;
        if (status.live_one) begin
          cmd.batch_clear = 1'b1;
          state_next      = hs_pkg::ST_LOAD;
        end else begin
          state_next = hs_pkg::ST_SIFT_READ;
        end
      end
      default: begin
        state_next    = hs_pkg::ST_LOAD;
        building_next = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/hs_datapath.sv
`default_nettype none

module hs_datapath (
  input  logic               clk,
  input  logic               rst,
  input  hs_pkg::hs_cmd_t    cmd,
  output hs_pkg::hs_status_t status,
  hs_in_if.sink              items,
  hs_out_if.source           results
);

  localparam int unsigned AW = hs_pkg::ADDR_W;
  localparam int unsigned CW = hs_pkg::CNT_W;
  localparam int unsigned KW = hs_pkg::CHILD_W;
  localparam int unsigned DW = hs_pkg::DATA_W;
  localparam logic [CW-1:0] CAP = CW'(hs_pkg::MAX_ITEMS);

  logic [CW-1:0]        count;
  logic                 ovf;
  logic [CW-1:0]        live;
  logic [AW-1:0]        bidx;
  logic [AW-1:0]        node;
  logic signed [DW-1:0] cur;

  logic signed [DW-1:0] out_value;
  logic                 out_last;
  logic                 out_ovf;
  logic                 out_valid;

  logic                 accept;
  logic                 store;
  logic [CW-1:0]        live_m1;
  logic [KW-1:0]        left;
  logic [KW-1:0]        right;
  logic [KW-1:0]        live_ext;
  logic                 l_ok;
  logic                 r_ok;
  logic signed [DW-1:0] rd_a;
  logic signed [DW-1:0] rd_b;
  logic [DW-1:0]        rd_data_a;
  logic [DW-1:0]        rd_data_b;
  logic signed [DW-1:0] best;
  logic [AW-1:0]        top;
  logic                 top_is_node;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [DW-1:0]        wr_data;
  logic [AW-1:0]        rd_addr_a;
  logic [AW-1:0]        rd_addr_b;

  assign items.ready = cmd.load_en;
  assign accept      = items.valid && items.ready;
  assign store       = accept && (count < CAP);

  assign live_m1  = live - CW'(1);
  assign left     = {1'b0, node, 1'b1};
  assign right    = left + KW'(1);
  assign live_ext = {1'b0, live};
  assign l_ok     = left < live_ext;
  assign r_ok     = right < live_ext;
  assign rd_a     = $signed(rd_data_a);
  assign rd_b     = $signed(rd_data_b);

  // pick the larger child; ties keep the node
  always_comb begin
    best        = cur;
    top         = node;
    top_is_node = 1'b1;
    if (l_ok && (rd_a > best)) begin
      best        = rd_a;
      top         = left[AW-1:0];
      top_is_node = 1'b0;
    end
    if (r_ok && (rd_b > best)) begin
      best        = rd_b;
      top         = right[AW-1:0];
      top_is_node = 1'b0;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      hs_pkg::RD_BIDX: begin
        rd_addr_a = bidx;
        rd_addr_b = bidx;
      end
      hs_pkg::RD_EXTRACT: begin
        rd_addr_a = '0;
        rd_addr_b = live_m1[AW-1:0];
      end
      default: begin
        rd_addr_a = left[AW-1:0];
        rd_addr_b = right[AW-1:0];
      end
    endcase
  end

  always_comb begin
    if (cmd.sift_cmp) begin
      wr_en   = 1'b1;
      wr_addr = node;
      wr_data = top_is_node ? cur : best;
    end else begin
      wr_en   = store;
      wr_addr = count[AW-1:0];
      wr_data = items.value;
    end
  end

  hs_ram #(
    .WIDTH (DW),
    .DEPTH (hs_pkg::MAX_ITEMS)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (store) begin
        count <= count + CW'(1);
      end else if (accept) begin
        ovf <= 1'b1;
      end
      if (cmd.batch_clear) begin
        count <= '0;
        ovf   <= 1'b0;
      end
      if (cmd.ext_cap) begin
        out_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_init) begin
      live <= count;
      bidx <= count[CW-1:1] - AW'(1);
    end
    if (cmd.bidx_dec) begin
      bidx <= bidx - AW'(1);
    end
    if (cmd.node_from_bidx) begin
      node <= bidx;
    end
    if (cmd.cur_from_a) begin
      cur <= rd_a;
    end
    if (cmd.sift_cmp && !top_is_node) begin
      node <= top;
    end
    // old root goes out; last live entry restarts the sift from the root
    if (cmd.ext_cap) begin
      out_value <= rd_a;
      out_last  <= (live == CW'(1));
      out_ovf   <= ovf;
      cur       <= rd_b;
      live      <= live_m1;
      node      <= '0;
    end
  end

  assign results.valid        = out_valid;
  assign results.sorted_value = out_value;
  assign results.last_result  = out_last;
  assign results.overflowed   = out_ovf;

  assign status.last_accepted = accept && items.last_item;
  assign status.n_small       = count < CW'(2);
  assign status.bidx_zero     = (bidx == '0);
  assign status.sift_done     = top_is_node;
  assign status.out_free      = !out_valid || results.ready;
  assign status.live_one      = (live == CW'(1));

  a_cap_free: assert property (@(posedge clk) disable iff (rst)
    cmd.ext_cap |-> !out_valid)
    else $error("result register overwritten before it was taken");

  a_node_live: assert property (@(posedge clk) disable iff (rst)
    cmd.sift_cmp |-> ({1'b0, node} < live))
    else $error("sift step outside the live heap");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CAP)
    else $error("item count beyond capacity");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.batch_clear |=> (count == '0) && !ovf)
    else $error("batch state not cleared at batch end");

endmodule

`default_nettype wire

// File: rtl/heap_sorter_unit.sv
`default_nettype none

// Heap sorter: takes a batch of signed 32-bit words, one per cycle, and
// returns them largest first once the word marked last arrives; the smallest
// result carries last_result. Up to MAX_ITEMS (16) words are kept; further
// words are dropped and every result of that batch has overflowed set. No
// input is taken while a batch is being sorted. After the last word, the heap
// is built by sifting down each internal node in turn, from the last one to
// the root. Each result is then taken from the root; the last live word
// refills the root and sifts down one level per compare step, and the final
// result needs no sift. The pace is set by the single write port of the store
// and the one compare step per level. A finished result waits in an output
// register while the next sift runs.
module heap_sorter_unit (
  input  logic     clk,
  input  logic     rst,
  hs_in_if.sink    items,
  hs_out_if.source results
);

  hs_pkg::hs_cmd_t    cmd;
  hs_pkg::hs_status_t status;

  hs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  hs_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .items   (items),
    .results (results)
  );

endmodule

`default_nettype wire
